// ===== sv/stc_pkg.sv =====
`default_nettype none
package stc_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int ADDR_W    = 12;
  localparam int LEN_W     = 13;
  localparam int DELAY_W   = 16;
  localparam int TIDX_W    = 14;
  localparam int PART_W    = 24;
  localparam int STAGE_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam logic [LEN_W-1:0] MAX_WORDS = 13'd4096;
  localparam logic [LEN_W-1:0] MIN_WORDS = 13'd2;

  // configuration register indexes (stage words use indexes below CFG_LAST)
  localparam logic [CFG_IDX_W-1:0] CFG_LAST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFLEN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE    = 3'd6;

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 3;

  localparam int MOD_LANES = 3;
  localparam int LANE_WR   = 0;
  localparam int LANE_STOP = 1;
  localparam int LANE_PRE  = 2;

  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] sample;
  } stc_item_t;

  // first field sits in the highest bits
  typedef struct packed {
    logic              pad;
    logic              triggered;
    logic              armed;
    logic              wrapped;
    logic [TIDX_W-1:0] trigger_index;
    logic              done_res;
    logic [31:0]       write_word;
    logic [ADDR_W-1:0] write_addr;
    logic              mem_write;
  } stc_result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } stc_mod_stat_t;

endpackage
`default_nettype wire

// ===== sv/stc_front.sv =====
`default_nettype none
module stc_front import stc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [SAMPLE_W-1:0] in_tdata,
  input  wire logic                in_tuser,
  output logic                     item_valid_o,
  output stc_item_t                item_o,
  input  wire logic                item_pop_i
);

  stc_item_t           q_r [QDEPTH];
  logic [QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push;
  stc_item_t           entry;

  assign in_tready    = (cnt_r != QCNT_W'(QDEPTH));
  assign push         = in_tvalid && in_tready;
  assign item_valid_o = (cnt_r != '0);
  assign item_o       = q_r[rptr_r];

  // a start request carries no sample
  always_comb begin
    entry.start  = in_tuser;
    entry.sample = in_tuser ? '0 : in_tdata;
  end

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = item_pop_i ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + QCNT_W'(push) - QCNT_W'(item_pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= entry;
    end
  end

endmodule
`default_nettype wire

// ===== sv/stc_modseq.sv =====
`default_nettype none
module stc_modseq import stc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start_i,
  input  wire logic [LEN_W-1:0]  len_i,
  input  wire logic [ADDR_W-1:0] dividend_i [MOD_LANES],
  output logic [ADDR_W-1:0]      rem_o [MOD_LANES],
  output stc_mod_stat_t          stat_o
);

  localparam int CNT_W = $clog2(ADDR_W + 1);

  logic              start_r;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] rem_r [MOD_LANES];
  logic [ADDR_W-1:0] rem_nxt [MOD_LANES];
  logic [ADDR_W-1:0] sh_r [MOD_LANES];
  logic [ADDR_W-1:0] sh_nxt [MOD_LANES];
  logic [LEN_W-1:0]  trial [MOD_LANES];

  assign stat_o.busy = start_r || busy_r || done_r;
  assign stat_o.done = done_r;

  // restoring reduction, one dividend bit per cycle in each lane
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    for (int i = 0; i < MOD_LANES; i++) begin
      trial[i]   = {rem_r[i], sh_r[i][ADDR_W-1]};
      rem_nxt[i] = rem_r[i];
      sh_nxt[i]  = sh_r[i];
      if (start_r) begin
        rem_nxt[i] = '0;
        sh_nxt[i]  = dividend_i[i];
      end else if (busy_r) begin
        rem_nxt[i] = (trial[i] >= len_i) ? ADDR_W'(trial[i] - len_i) : ADDR_W'(trial[i]);
        sh_nxt[i]  = {sh_r[i][ADDR_W-2:0], 1'b0};
      end
    end
    if (start_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(ADDR_W);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b0;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      start_r <= start_i;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MOD_LANES; i++) begin
      rem_r[i] <= rem_nxt[i];
      sh_r[i]  <= sh_nxt[i];
    end
  end

  assign rem_o = rem_r;

endmodule
`default_nettype wire

// ===== sv/stc_back.sv =====
`default_nettype none
module stc_back import stc_pkg::*; #(
  parameter int STAGES = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             item_valid_i,
  input  wire stc_item_t                        item_i,
  output logic                                  item_pop_o,
  input  wire logic [STAGES-1:0][STAGE_W-1:0]   stage_words_i,
  input  wire logic [1:0]                       last_stage_i,
  input  wire logic [LEN_W-1:0]                 len_i,
  input  wire logic [ADDR_W-1:0]                pre_i,
  input  wire logic                             cfg_fire_i,
  input  wire stc_mod_stat_t                    mod_stat_i,
  input  wire logic [ADDR_W-1:0]                mod_rem_i [MOD_LANES],
  output logic [ADDR_W-1:0]                     wr_addr_o,
  output logic [ADDR_W-1:0]                     stop_addr_o,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output stc_result_t                           out_result_o
);

  localparam int SIW = (STAGES > 1) ? $clog2(STAGES) : 1;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_FILL      = 3'd1;
  localparam logic [2:0] PH_LOOK      = 3'd2;
  localparam logic [2:0] PH_WAIT      = 3'd3;
  localparam logic [2:0] PH_AFTER     = 3'd4;
  localparam logic [2:0] PH_FREE      = 3'd5;
  localparam logic [2:0] PH_DONE_TRIG = 3'd6;
  localparam logic [2:0] PH_DONE_FREE = 3'd7;

  logic [2:0]         phase_r, phase_nxt;
  logic [ADDR_W-1:0]  wr_r, wr_nxt;
  logic [ADDR_W-1:0]  wr_mod_r, wr_mod_nxt;
  logic [PART_W-1:0]  part_r, part_nxt;
  logic [1:0]         slot_r, slot_nxt;
  logic [1:0]         sidx_r, sidx_nxt;
  logic [DELAY_W-1:0] dly_r, dly_nxt;
  logic [ADDR_W-1:0]  stop_r, stop_nxt;
  logic [ADDR_W-1:0]  stop_mod_r, stop_mod_nxt;
  logic [ADDR_W-1:0]  pre_mod_r, pre_mod_nxt;
  logic               wrap_r, wrap_nxt;
  logic               out_valid_r;
  stc_result_t        out_data_r;

  logic               blocked;
  logic               pop;
  logic               res_v;
  stc_result_t        res;
  logic               fire;
  logic [1:0]         fin;
  logic [ADDR_W-1:0]  arm;
  logic [STAGE_W-1:0] sw;
  logic [TIDX_W-1:0]  stop_sum;
  logic [TIDX_W-1:0]  tsum;
  logic [ADDR_W-1:0]  stop_calc;
  logic [ADDR_W-1:0]  tpos;
  logic [LEN_W-1:0]   wr_inc;
  logic               done_ph;

  assign blocked    = cfg_fire_i || mod_stat_i.busy;
  assign pop        = item_valid_i && !blocked && (!out_valid_r || out_tready);
  assign item_pop_o = pop;
  assign wr_addr_o  = wr_r;
  assign stop_addr_o = stop_r;
  assign out_tvalid   = out_valid_r;
  assign out_result_o = out_data_r;

  always_comb begin
    fin = (last_stage_i > 2'(STAGES - 1)) ? 2'(STAGES - 1) : last_stage_i;
    arm = (pre_i < ADDR_W'(len_i - 1'b1)) ? pre_i : ADDR_W'(len_i - 1'b1);
    sw  = stage_words_i[sidx_r[SIW-1:0]];
    // stop = (wr mod len - pre mod len) mod len, both already reduced
    stop_sum  = TIDX_W'(len_i) - TIDX_W'(pre_mod_r) + TIDX_W'(wr_mod_r);
    stop_calc = (stop_sum >= TIDX_W'(len_i)) ? ADDR_W'(stop_sum - TIDX_W'(len_i))
                                             : ADDR_W'(stop_sum);
  end

  always_comb begin
    phase_nxt    = phase_r;
    wr_nxt       = wr_r;
    wr_mod_nxt   = wr_mod_r;
    part_nxt     = part_r;
    slot_nxt     = slot_r;
    sidx_nxt     = sidx_r;
    dly_nxt      = dly_r;
    stop_nxt     = stop_r;
    stop_mod_nxt = stop_mod_r;
    pre_mod_nxt  = pre_mod_r;
    wrap_nxt     = wrap_r;
    res          = '0;
    res_v        = 1'b0;
    fire         = 1'b0;
    wr_inc       = LEN_W'(wr_r) + 1'b1;
    tsum         = '0;
    tpos         = '0;
    done_ph      = 1'b0;

    if (mod_stat_i.done) begin
      wr_mod_nxt   = mod_rem_i[LANE_WR];
      stop_mod_nxt = mod_rem_i[LANE_STOP];
      pre_mod_nxt  = mod_rem_i[LANE_PRE];
    end

    if (pop) begin
      if (item_i.start) begin
        wr_nxt     = '0;
        wr_mod_nxt = '0;
        part_nxt   = '0;
        slot_nxt   = '0;
        sidx_nxt   = '0;
        dly_nxt    = '0;
        wrap_nxt   = 1'b0;
        if (stage_words_i[0][7:0] == '0) begin
          phase_nxt    = PH_FREE;
          stop_nxt     = ADDR_W'(len_i - 1'b1);
          stop_mod_nxt = ADDR_W'(len_i - 1'b1);
        end else begin
          phase_nxt    = PH_FILL;
          stop_nxt     = '0;
          stop_mod_nxt = '0;
        end
      end else if (phase_r != PH_IDLE) begin
        res_v = 1'b1;
        if (phase_r != PH_DONE_TRIG && phase_r != PH_DONE_FREE) begin
          if (phase_r == PH_FILL && wr_r >= arm) begin
            phase_nxt = PH_LOOK;
          end
          if (phase_nxt == PH_LOOK) begin
            if ((item_i.sample & sw[7:0]) == sw[15:8]) begin
              if (sw[31:16] == '0) begin
                fire = 1'b1;
              end else begin
                dly_nxt   = sw[31:16];
                phase_nxt = PH_WAIT;
              end
            end
          end else if (phase_nxt == PH_WAIT) begin
            dly_nxt = dly_r - 1'b1;
            fire    = (dly_nxt == '0);
          end
          if (fire) begin
            if (sidx_r >= fin) begin
              stop_nxt     = stop_calc;
              stop_mod_nxt = stop_calc;
              phase_nxt    = PH_AFTER;
            end else begin
              sidx_nxt  = sidx_r + 1'b1;
              phase_nxt = PH_LOOK;
            end
          end

          if (slot_r != 2'd3) begin
            part_nxt = {part_r[PART_W-SAMPLE_W-1:0], item_i.sample};
            slot_nxt = slot_r + 1'b1;
          end else begin
            res.mem_write  = 1'b1;
            res.write_addr = wr_r;
            res.write_word = {part_r, item_i.sample};
            if (wr_inc >= len_i) begin
              wr_nxt   = '0;
              wrap_nxt = 1'b1;
            end else begin
              wr_nxt = ADDR_W'(wr_inc);
            end
            wr_mod_nxt = wr_nxt;
            part_nxt   = '0;
            slot_nxt   = '0;
            if (wr_nxt == stop_nxt) begin
              if (phase_nxt == PH_AFTER) begin
                phase_nxt = PH_DONE_TRIG;
              end else if (phase_nxt == PH_FREE) begin
                phase_nxt = PH_DONE_FREE;
              end
            end
          end
        end

        done_ph = (phase_nxt == PH_DONE_TRIG) || (phase_nxt == PH_DONE_FREE);
        if (done_ph) begin
          tsum = TIDX_W'(stop_mod_nxt) + TIDX_W'(pre_mod_r);
          tpos = (tsum >= TIDX_W'(len_i)) ? ADDR_W'(tsum - TIDX_W'(len_i)) : ADDR_W'(tsum);
          res.trigger_index = {tpos, 2'b11};
        end
        res.done_res  = done_ph;
        res.wrapped   = wrap_nxt;
        res.armed     = (phase_nxt == PH_LOOK) || (phase_nxt == PH_WAIT);
        res.triggered = (phase_nxt == PH_AFTER) || (phase_nxt == PH_DONE_TRIG);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      wr_r        <= '0;
      wr_mod_r    <= '0;
      part_r      <= '0;
      slot_r      <= '0;
      sidx_r      <= '0;
      dly_r       <= '0;
      stop_r      <= '0;
      stop_mod_r  <= '0;
      pre_mod_r   <= '0;
      wrap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      wr_r       <= wr_nxt;
      wr_mod_r   <= wr_mod_nxt;
      part_r     <= part_nxt;
      slot_r     <= slot_nxt;
      sidx_r     <= sidx_nxt;
      dly_r      <= dly_nxt;
      stop_r     <= stop_nxt;
      stop_mod_r <= stop_mod_nxt;
      pre_mod_r  <= pre_mod_nxt;
      wrap_r     <= wrap_nxt;
      if (pop && res_v) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_v) begin
      out_data_r <= res;
    end
  end

  // no request is taken while the address reduction is running
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mod_stat_i.busy |-> !pop)
    else $error("request taken during address reduction");

  // reduced addresses stay below the buffer length once settled
  a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!mod_stat_i.busy && !cfg_fire_i && !$past(cfg_fire_i)) |->
      (wr_mod_r < len_i) && (pre_mod_r < len_i) && (stop_mod_r < len_i))
    else $error("reduced address out of range");

  // a finished capture leaves the write address alone until restarted
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_DONE_TRIG || phase_r == PH_DONE_FREE) && !(pop && item_i.start))
      |=> $stable(wr_r))
    else $error("write address moved after capture finished");

  // a word write only happens on the fourth sample of a word
  a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && res_v && res.mem_write) |=> $past(slot_r) == 2'd3 && slot_r == 2'd0)
    else $error("word written out of slot order");

endmodule
`default_nettype wire

// ===== sv/staged_trigger_capture.sv =====
// Requests are queued at the input; results are registered at the output.
// Throughput: one request per cycle, set by the single-cycle capture engine,
// while the output is not stalled. Each configuration write holds the engine
// while a bit-serial unit reduces the addresses modulo the buffer length.
// Reset: synchronous, active low; clears capture state to idle and loads
// the register defaults. No clearing pass.
`default_nettype none
module staged_trigger_capture import stc_pkg::*; #(
  parameter int STAGES = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // sample
  input  wire logic                 in_tuser,   // kind
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // mem_write, write_addr, write_word, done_res, trigger_index, wrapped,
  // armed, triggered, zero pad
  output logic [63:0]               out_tdata,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [STAGES-1:0][STAGE_W-1:0] stage_r;
  logic [1:0]                     last_r;
  logic [LEN_W-1:0]               buflen_r;
  logic [ADDR_W-1:0]              pre_r;
  logic [LEN_W-1:0]               len;
  logic                           cfg_fire;

  logic                           item_valid;
  stc_item_t                      item;
  logic                           item_pop;
  stc_mod_stat_t                  mod_stat;
  logic [ADDR_W-1:0]              mod_div [MOD_LANES];
  logic [ADDR_W-1:0]              mod_rem [MOD_LANES];
  logic [ADDR_W-1:0]              wr_addr;
  logic [ADDR_W-1:0]              stop_addr;
  stc_result_t                    result;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_tdata = result;

  // clamp the buffer length into its legal range
  always_comb begin
    if (buflen_r > MAX_WORDS) begin
      len = MAX_WORDS;
    end else if (buflen_r < MIN_WORDS) begin
      len = MIN_WORDS;
    end else begin
      len = buflen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r  <= '0;
      last_r   <= '0;
      buflen_r <= MAX_WORDS;
      pre_r    <= '0;
    end else if (cfg_fire) begin
      for (int i = 0; i < STAGES; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          stage_r[i] <= cfg_data;
        end
      end
      case (cfg_index)
        CFG_LAST:   last_r   <= cfg_data[1:0];
        CFG_BUFLEN: buflen_r <= cfg_data[LEN_W-1:0];
        CFG_PRE:    pre_r    <= cfg_data[ADDR_W-1:0];
        default:    ;
      endcase
    end
  end

  assign mod_div[LANE_WR]   = wr_addr;
  assign mod_div[LANE_STOP] = stop_addr;
  assign mod_div[LANE_PRE]  = pre_r;

  stc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  stc_modseq u_modseq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (cfg_fire),
    .len_i      (len),
    .dividend_i (mod_div),
    .rem_o      (mod_rem),
    .stat_o     (mod_stat)
  );

  stc_back #(
    .STAGES (STAGES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .stage_words_i (stage_r),
    .last_stage_i  (last_r),
    .len_i         (len),
    .pre_i         (pre_r),
    .cfg_fire_i    (cfg_fire),
    .mod_stat_i    (mod_stat),
    .mod_rem_i     (mod_rem),
    .wr_addr_o     (wr_addr),
    .stop_addr_o   (stop_addr),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_result_o  (result)
  );

endmodule
`default_nettype wire

// ===== sim/tb_staged_trigger_capture.sv =====
`timescale 1ns / 1ps
module tb_staged_trigger_capture;
  import stc_pkg::*;

  localparam int LIMIT        = 1_000_000;
  localparam int RANDOM_ITEMS = 600;
  localparam int MAX_REPORTS  = 10;
  localparam int SETTLE       = 8;
  localparam int PHASE_CAP    = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE0 = 3'd0;

  typedef enum logic [2:0] {
    CAP_IDLE, CAP_FILL, CAP_LOOK, CAP_WAIT, CAP_AFTER, CAP_FREE, CAP_DONE_TRIG, CAP_DONE_FREE
  } cap_phase_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    bit                   kind;
    logic [7:0]           sample;
    bit                   typed;
    stc_result_t          res;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic [7:0]           in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_tready;
  logic                 out_tvalid;
  logic [63:0]          out_tdata;   // mem_write, write_addr, write_word, done_res,
                                     // trigger_index, wrapped, armed, triggered, pad
  logic                 cfg_ready;

  staged_trigger_capture u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // capture model state and register copy
  logic [31:0]  m_stage [4];
  logic [1:0]   m_last;
  logic [12:0]  m_buflen;
  logic [11:0]  m_pre;
  cap_phase_t   m_phase;
  int unsigned  m_wr, m_part, m_slot, m_sidx, m_delay, m_stop;
  bit           m_wrap;

  stc_result_t  pending_results [$];
  dir_row_t     directed_rows [$];
  bit           steady = 1'b0;
  int           cycles = 0;
  int           n_requests = 0;
  int           n_results = 0;
  int           n_captures = 0;
  int           n_triggered = 0;
  int           n_errors = 0;
  int           n_reports = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned eff_len();
    int unsigned b;
    b = m_buflen;
    if (b > 4096) b = 4096;
    if (b < 2) b = 2;
    return b;
  endfunction

  function automatic void model_reset();
    foreach (m_stage[i]) m_stage[i] = '0;
    m_last   = '0;
    m_buflen = MAX_WORDS;
    m_pre    = '0;
    m_phase  = CAP_IDLE;
    m_wr     = 0;
    m_part   = 0;
    m_slot   = 0;
    m_sidx   = 0;
    m_delay  = 0;
    m_stop   = 0;
    m_wrap   = 1'b0;
  endfunction

  function automatic void model_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    if (idx < CFG_LAST) m_stage[idx[1:0]] = data;
    else if (idx == CFG_LAST) m_last = data[1:0];
    else if (idx == CFG_BUFLEN) m_buflen = data[12:0];
    else if (idx == CFG_PRE) m_pre = data[11:0];
  endfunction

  function automatic void stage_fire(int unsigned b);
    if (m_sidx >= m_last) begin
      m_stop  = ((m_wr % b) + b - (m_pre % b)) % b;
      m_phase = CAP_AFTER;
    end else begin
      m_sidx  = (m_sidx + 1) & 3;
      m_phase = CAP_LOOK;
    end
  endfunction

  // advance the capture model by one request; returns 1 when a result follows
  function automatic bit capture_step(bit kind, logic [7:0] s, output stc_result_t r);
    int unsigned b, arm, t;
    logic [31:0] w;
    bit done;
    r = '0;
    b = eff_len();
    if (kind) begin
      m_wr = 0;
      m_part = 0;
      m_slot = 0;
      m_sidx = 0;
      m_delay = 0;
      m_wrap = 1'b0;
      if (m_stage[0][7:0] == 8'h00) begin
        m_phase = CAP_FREE;
        m_stop = b - 1;
      end else begin
        m_phase = CAP_FILL;
        m_stop = 0;
      end
      return 1'b0;
    end
    if (m_phase == CAP_IDLE) return 1'b0;
    if (m_phase != CAP_DONE_TRIG && m_phase != CAP_DONE_FREE) begin
      if (m_phase == CAP_FILL) begin
        arm = (m_pre < b - 1) ? m_pre : b - 1;
        if (m_wr >= arm) m_phase = CAP_LOOK;
      end
      if (m_phase == CAP_LOOK) begin
        w = m_stage[m_sidx[1:0]];
        if ((s & w[7:0]) == w[15:8]) begin
          if (w[31:16] == 16'h0000) stage_fire(b);
          else begin
            m_delay = w[31:16];
            m_phase = CAP_WAIT;
          end
        end
      end else if (m_phase == CAP_WAIT) begin
        m_delay = (m_delay - 1) & 32'h0000_FFFF;
        if (m_delay == 0) stage_fire(b);
      end
      if (m_slot < 3) begin
        m_part = ((m_part << 8) | s) & 32'h00FF_FFFF;
        m_slot++;
      end else begin
        r.mem_write  = 1'b1;
        r.write_addr = m_wr[11:0];
        r.write_word = {m_part[23:0], s};
        m_wr++;
        if (m_wr >= b) begin
          m_wr = 0;
          m_wrap = 1'b1;
        end
        m_part = 0;
        m_slot = 0;
        if (m_wr == m_stop) begin
          if (m_phase == CAP_AFTER) begin
            m_phase = CAP_DONE_TRIG;
            n_captures++;
            n_triggered++;
          end else if (m_phase == CAP_FREE) begin
            m_phase = CAP_DONE_FREE;
            n_captures++;
          end
        end
      end
    end
    done = (m_phase == CAP_DONE_TRIG || m_phase == CAP_DONE_FREE);
    r.done_res = done;
    if (done) begin
      t = (((m_stop % b) + (m_pre % b)) % b) * 4 + 3;
      r.trigger_index = t[13:0];
    end
    r.wrapped   = m_wrap;
    r.armed     = (m_phase == CAP_LOOK || m_phase == CAP_WAIT);
    r.triggered = (m_phase == CAP_AFTER || m_phase == CAP_DONE_TRIG);
    return 1'b1;
  endfunction

  function automatic stc_result_t mk_res(bit we, logic [11:0] addr, logic [31:0] word, bit done,
                                         logic [13:0] tidx, bit wrap, bit arm, bit trig);
    stc_result_t r;
    r = '0;
    r.mem_write     = we;
    r.write_addr    = addr;
    r.write_word    = word;
    r.done_res      = done;
    r.trigger_index = tidx;
    r.wrapped       = wrap;
    r.armed         = arm;
    r.triggered     = trig;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    dir_row_t d;
    d = '{default: '0};
    d.is_cfg = 1'b1;
    d.idx = idx;
    d.data = data;
    return d;
  endfunction

  function automatic dir_row_t req_row(bit kind, logic [7:0] sample);
    dir_row_t d;
    d = '{default: '0};
    d.kind = kind;
    d.sample = sample;
    return d;
  endfunction

  function automatic dir_row_t typed_row(logic [7:0] sample, stc_result_t res);
    dir_row_t d;
    d = req_row(1'b0, sample);
    d.typed = 1'b1;
    d.res = res;
    return d;
  endfunction

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (steady || sel < 60) return 0;
    if (sel < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_stage();
    logic [7:0]  mk, vl;
    logic [15:0] dl;
    int          sel;
    if ($urandom_range(0, 29) == 0) return 32'hFFFF_FFFF;
    mk = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    vl = ($urandom_range(0, 7) == 0) ? 8'($urandom) : (8'($urandom) & mk);
    sel = $urandom_range(0, 99);
    if (sel < 65) dl = 16'h0000;
    else if (sel < 95) dl = 16'($urandom_range(1, 6));
    else dl = 16'($urandom);
    return {dl, vl, mk};
  endfunction

  // bias toward the pattern of the stage the capture is hunting for
  function automatic logic [7:0] next_sample();
    logic [31:0] w;
    logic [7:0]  rnd;
    rnd = 8'($urandom);
    if ((m_phase == CAP_FILL || m_phase == CAP_LOOK) && $urandom_range(0, 1) == 1) begin
      w = m_stage[m_sidx[1:0]];
      return (rnd & ~w[7:0]) | w[15:8];
    end
    return rnd;
  endfunction

  task automatic send_request(bit kind, logic [7:0] sample, bit typed, stc_result_t tres);
    int          gap;
    bit          has;
    stc_result_t r;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= sample;
    do @(posedge clk); while (!in_tready);
    has = capture_step(kind, sample, r);
    if (has) pending_results.push_back(typed ? tres : r);
    if (has || kind) n_requests++;
  endtask

  // drop valid, drain results, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    model_config(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_settings(bit all);
    int          sel;
    logic [12:0] len;
    logic [11:0] pre;
    int unsigned b;
    for (int i = 0; i < 4; i++) begin
      if (all || $urandom_range(0, 1) == 1) begin
        write_reg(CFG_IDX_W'(CFG_STAGE0 + i), rand_stage());
      end
    end
    if (all || $urandom_range(0, 1) == 1) write_reg(CFG_LAST, $urandom);
    if (all || $urandom_range(0, 1) == 1) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) len = 13'($urandom_range(2, 8));
      else if (sel < 80) len = 13'($urandom_range(9, 40));
      else if (sel < 88) len = 13'($urandom_range(0, 1));
      else if (sel < 94) len = 13'($urandom_range(41, 200));
      else len = 13'($urandom_range(4096, 8191));
      write_reg(CFG_BUFLEN, ($urandom & 32'hFFFF_E000) | len);
    end
    if (all || $urandom_range(0, 1) == 1) begin
      b = eff_len();
      sel = $urandom_range(0, 9);
      if (sel < 5) pre = 12'($urandom_range(0, b + 1));
      else if (sel < 6) pre = 12'($urandom);
      else pre = 12'h000;
      write_reg(CFG_PRE, ($urandom & 32'hFFFF_F000) | pre);
    end
  endtask

  initial begin
    int run;
    run = 0;
    forever begin
      @(negedge clk);
      if (steady) begin
        out_tready <= 1'b1;
        run = 0;
      end else if (run > 0) begin
        run--;
      end else if (out_tready) begin
        out_tready <= 1'b0;
        run = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b1;
        run = $urandom_range(0, 20);
      end
    end
  end

  always @(posedge clk) begin : result_check
    stc_result_t got, want;
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("status: fail");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      got.pad = 1'b0;
      n_results++;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_reports < MAX_REPORTS) begin
          n_reports++;
          $display("unexpected result %h at cycle %0d", out_tdata, cycles);
        end
      end else begin
        want = pending_results.pop_front();
        want.pad = 1'b0;
        if (got !== want) begin
          n_errors++;
          if (n_reports < MAX_REPORTS) begin
            n_reports++;
            $display("mismatch %0d exp we=%0b a=%03h w=%08h d=%0b ti=%0d wr=%0b ar=%0b tg=%0b",
                     n_results, want.mem_write, want.write_addr, want.write_word,
                     want.done_res, want.trigger_index, want.wrapped, want.armed,
                     want.triggered);
            $display("         got we=%0b a=%03h w=%08h d=%0b ti=%0d wr=%0b ar=%0b tg=%0b",
                     got.mem_write, got.write_addr, got.write_word, got.done_res,
                     got.trigger_index, got.wrapped, got.armed, got.triggered);
          end
        end
      end
    end
  end

  initial begin
    int          base, cnt, extra;
    bit          first;
    stc_result_t none;
    logic [7:0]  seq [13];
    none = '0;
    model_reset();

    // free-running capture on the shortest buffer
    directed_rows.push_back(cfg_row(CFG_BUFLEN, 32'h0000_0000));
    directed_rows.push_back(req_row(1'b0, 8'hFF));   // idle, ignored
    directed_rows.push_back(req_row(1'b1, 8'hA5));
    directed_rows.push_back(typed_row(8'h00, none));
    directed_rows.push_back(typed_row(8'hFF, none));
    directed_rows.push_back(typed_row(8'h80, none));
    directed_rows.push_back(typed_row(8'h01, mk_res(1'b1, 12'h000, 32'h00FF_8001, 1'b1,
                                                    14'd7, 1'b0, 1'b0, 1'b0)));
    directed_rows.push_back(typed_row(8'h33, mk_res(1'b0, 12'h000, 32'h0000_0000, 1'b1,
                                                    14'd7, 1'b0, 1'b0, 1'b0)));
    // all-ones register data: longest buffer, largest pre-trigger, last stage 3
    directed_rows.push_back(cfg_row(CFG_BUFLEN, 32'hFFFF_FFFF));
    directed_rows.push_back(cfg_row(CFG_PRE, 32'hFFFF_FFFF));
    directed_rows.push_back(cfg_row(CFG_LAST, 32'hFFFF_FFFF));
    directed_rows.push_back(cfg_row(CFG_STAGE0, 32'h0000_8080));
    directed_rows.push_back(req_row(1'b1, 8'h00));
    directed_rows.push_back(req_row(1'b0, 8'hFF));
    directed_rows.push_back(req_row(1'b0, 8'hFF));
    directed_rows.push_back(req_row(1'b0, 8'hFF));
    directed_rows.push_back(typed_row(8'hFF, mk_res(1'b1, 12'h000, 32'hFFFF_FFFF, 1'b0,
                                                    14'd0, 1'b0, 1'b0, 1'b0)));
    // two stages with a delay, plus a stage whose value lies outside its mask
    directed_rows.push_back(cfg_row(CFG_BUFLEN, 32'h0000_0004));
    directed_rows.push_back(cfg_row(CFG_PRE, 32'h0000_0001));
    directed_rows.push_back(cfg_row(CFG_STAGE0, 32'h0000_50F0));
    directed_rows.push_back(cfg_row(CFG_IDX_W'(CFG_STAGE0 + 1), 32'h0002_FFFF));
    directed_rows.push_back(cfg_row(CFG_IDX_W'(CFG_STAGE0 + 2), 32'h0000_100F));
    directed_rows.push_back(cfg_row(CFG_IDX_W'(CFG_STAGE0 + 3), 32'hFFFF_FFFF));
    directed_rows.push_back(cfg_row(CFG_LAST, 32'h0000_0001));
    directed_rows.push_back(req_row(1'b1, 8'hFF));
    seq = '{8'h11, 8'h22, 8'h5A, 8'h33, 8'h55, 8'hFF, 8'h00, 8'h01,
            8'h0F, 8'h10, 8'hF0, 8'h50, 8'hAA};
    foreach (seq[i]) directed_rows.push_back(req_row(1'b0, seq[i]));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_request(directed_rows[i].kind, directed_rows[i].sample,
                     directed_rows[i].typed, directed_rows[i].res);
      end
    end

    base = n_requests;
    first = 1'b1;
    while (n_requests - base < RANDOM_ITEMS) begin
      wait_idle();
      random_settings(first);
      first = 1'b0;
      steady = ($urandom_range(0, 4) == 0);
      send_request(1'b1, 8'($urandom), 1'b0, none);
      cnt = 0;
      extra = $urandom_range(1, 4);
      // run the capture through done, then a few ignored samples after it
      while (cnt < PHASE_CAP && extra > 0 && n_requests - base < RANDOM_ITEMS) begin
        if ($urandom_range(0, 149) == 0) send_request(1'b1, 8'($urandom), 1'b0, none);
        else send_request(1'b0, next_sample(), 1'b0, none);
        cnt++;
        if (m_phase == CAP_DONE_TRIG || m_phase == CAP_DONE_FREE) extra--;
      end
      steady = 1'b0;
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    n_errors += pending_results.size();
    $display("covered %0d requests and %0d checked results over %0d cycles",
             n_requests, n_results, cycles);
    $display("%0d captures ran to done, %0d of them triggered; %0d mismatches",
             n_captures, n_triggered, n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
